[sv/tsd_pkg.sv]
package tsd_pkg;

  localparam int CHANNELS    = 64;
  localparam int ADDR_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CH_W        = 6;
  localparam int SAMPLE_W    = 16;
  localparam int AMP_W       = 15;
  localparam int CNT_W       = 13;
  localparam int GCH_W       = 10;
  localparam int BLIND_W     = 12;
  localparam int DET_W       = 11;
  localparam int GRP_W       = 4;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [BLIND_W-1:0] BLIND_RESET = BLIND_W'(40);
  localparam logic [DET_W-1:0]   DET_RESET   = DET_W'(10);
  localparam logic [GRP_W-1:0]   GRP_RESET   = '0;
  localparam logic [AMP_W-1:0]   AMP_MAX     = '1;

  // input kinds (tuser)
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_LOAD   = 1'b1;

  // register indexes on the APB port
  localparam logic [1:0] REG_BLIND  = 2'd0;
  localparam logic [1:0] REG_DETECT = 2'd1;
  localparam logic [1:0] REG_GROUP  = 2'd2;

  typedef struct packed {
    logic [BLIND_W-1:0] blind;
    logic [DET_W-1:0]   detect;
    logic [GRP_W-1:0]   group;
  } cfg_t;

  // classified request: value is the clipped negated sample or the new threshold
  typedef struct packed {
    logic             is_load;
    logic [CH_W-1:0]  channel;
    logic [AMP_W-1:0] value;
  } item_t;

  typedef struct packed {
    logic signed [CNT_W-1:0] counter;
    logic [AMP_W-1:0]        peak;
    logic [AMP_W-1:0]        threshold;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  localparam entry_t ENTRY_RESET = '{
    counter:   CNT_W'(BLIND_RESET),
    peak:      '0,
    threshold: AMP_MAX
  };

endpackage

[sv/tsd_ram.sv]
module tsd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                      wr_data,
  input  logic                                  rd_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                      rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read returns the old word on a same-address write
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[sv/tsd_front.sv]
module tsd_front (
  input  logic                          in_valid,
  input  logic                          in_op,
  input  logic [tsd_pkg::CH_W-1:0]      in_channel,
  input  logic signed [tsd_pkg::SAMPLE_W-1:0] in_sample,
  input  logic [tsd_pkg::AMP_W-1:0]     in_threshold,
  input  logic                          queue_full,
  output logic                          in_ready,
  output logic                          push,
  output tsd_pkg::item_t                push_item
);

  logic                         in_range;
  logic [tsd_pkg::AMP_W-1:0]    mag;
  logic signed [tsd_pkg::SAMPLE_W-1:0] neg;

  // negated sample clipped to the positive range; non-positive values
  // can never beat a threshold or a peak, so they map to zero
  always_comb begin
    neg = -in_sample;
    if (in_sample == {1'b1, {(tsd_pkg::SAMPLE_W-1){1'b0}}}) begin
      mag = tsd_pkg::AMP_MAX;
    end else if (in_sample[tsd_pkg::SAMPLE_W-1]) begin
      mag = neg[tsd_pkg::AMP_W-1:0];
    end else begin
      mag = '0;
    end
  end

  assign in_range = 32'(in_channel) < tsd_pkg::CHANNELS;
  assign in_ready = !queue_full;
  assign push     = in_valid && !queue_full && in_range;

  always_comb begin
    push_item.is_load = (in_op == tsd_pkg::OP_LOAD);
    push_item.channel = in_channel;
    push_item.value   = (in_op == tsd_pkg::OP_LOAD) ? in_threshold : mag;
  end

endmodule

[sv/tsd_queue.sv]
module tsd_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  tsd_pkg::item_t push_item,
  output logic           full,
  input  logic           pop,
  output logic           empty,
  output tsd_pkg::item_t head
);

  tsd_pkg::item_t              slots [tsd_pkg::QUEUE_DEPTH];
  logic [tsd_pkg::QPTR_W-1:0]  wr_ptr;
  logic [tsd_pkg::QPTR_W-1:0]  rd_ptr;
  logic [tsd_pkg::QPTR_W:0]    count;

  assign full  = (count == (tsd_pkg::QPTR_W+1)'(tsd_pkg::QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[sv/tsd_back.sv]
module tsd_back (
  input  logic                        clk,
  input  logic                        rst,
  input  tsd_pkg::cfg_t               cfg,
  input  logic                        queue_empty,
  input  tsd_pkg::item_t              head,
  output logic                        pop,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [tsd_pkg::GCH_W-1:0]   out_channel,
  output logic [tsd_pkg::AMP_W-1:0]   out_peak
);

  logic                          advance;
  logic                          e_valid;
  tsd_pkg::item_t                e_item;
  logic [tsd_pkg::ADDR_W-1:0]    e_addr;
  logic [tsd_pkg::ADDR_W-1:0]    head_addr;
  logic [tsd_pkg::ENTRY_W-1:0]   rd_word;
  logic [tsd_pkg::CHANNELS-1:0]  entry_valid;
  logic                          fwd_hit;
  tsd_pkg::entry_t               fwd_entry;
  tsd_pkg::entry_t               cur;
  tsd_pkg::entry_t               upd;
  logic                          spike;
  logic signed [tsd_pkg::CNT_W-1:0] cnt_inc;
  logic signed [tsd_pkg::CNT_W-1:0] onset_cnt;
  logic signed [tsd_pkg::CNT_W-1:0] blind_cnt;

  assign advance   = !out_valid || out_ready;
  assign pop       = advance && !queue_empty;
  assign head_addr = head.channel[tsd_pkg::ADDR_W-1:0];
  assign e_addr    = e_item.channel[tsd_pkg::ADDR_W-1:0];

  tsd_ram #(
    .WIDTH (tsd_pkg::ENTRY_W),
    .DEPTH (tsd_pkg::CHANNELS)
  ) u_state_ram (
    .clk     (clk),
    .wr_en   (advance && e_valid),
    .wr_addr (e_addr),
    .wr_data (upd),
    .rd_en   (pop),
    .rd_addr (head_addr),
    .rd_data (rd_word)
  );

  // current entry: bypass from the write that raced our read, else RAM,
  // else reset contents for an entry never written
  always_comb begin
    if (fwd_hit) begin
      cur = fwd_entry;
    end else if (entry_valid[e_addr]) begin
      cur = tsd_pkg::entry_t'(rd_word);
    end else begin
      cur = tsd_pkg::ENTRY_RESET;
    end
  end

  assign cnt_inc   = cur.counter + 1'b1;
  assign onset_cnt = -tsd_pkg::CNT_W'(cfg.detect);
  assign blind_cnt = (cfg.blind > tsd_pkg::BLIND_W'(cfg.detect))
                   ? tsd_pkg::CNT_W'(cfg.blind - tsd_pkg::BLIND_W'(cfg.detect))
                   : '0;

  // phase update (a load only sets the threshold): blind (>0), armed (==0), onset (<0)
  always_comb begin
    upd   = cur;
    spike = 1'b0;
    if (e_item.is_load) begin
      upd.threshold = e_item.value;
    end else if (cur.counter > 0) begin
      upd.counter = cur.counter - 1'b1;
    end else if (cur.counter == 0) begin
      if (e_item.value > cur.threshold) begin
        upd.counter = onset_cnt;
        upd.peak    = e_item.value;
      end
    end else if (e_item.value > cur.peak) begin
      upd.counter = onset_cnt;
      upd.peak    = e_item.value;
    end else if (cnt_inc != 0) begin
      upd.counter = cnt_inc;
    end else begin
      upd.counter = blind_cnt;
      spike       = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      e_item    <= head;
      fwd_hit   <= e_valid && !queue_empty && (head_addr == e_addr);
      fwd_entry <= upd;
      out_channel <= tsd_pkg::GCH_W'(32'(cfg.group) * tsd_pkg::CHANNELS)
                   + tsd_pkg::GCH_W'(e_item.channel);
      out_peak    <= cur.peak;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      e_valid     <= 1'b0;
      out_valid   <= 1'b0;
      entry_valid <= '0;
    end else if (advance) begin
      e_valid   <= !queue_empty;
      out_valid <= e_valid && spike;
      if (e_valid) begin
        entry_valid[e_addr] <= 1'b1;
      end
    end
  end

endmodule

[sv/threshold_spike_detector_top.sv]
// Channel   Dir  Handshake                Payload
// s_        in   s_tvalid / s_tready      s_tuser: operation; s_tdata: channel, sample,
//                                         threshold_value
// m_        out  m_tvalid / m_tready      m_tdata: global_channel, peak_amplitude
// APB cfg   in   psel & penable & pwrite  blind_samples @0, detect_samples @4, group_index @8
//
// One request per clock sustained while m_ accepts; the per-channel state
// RAM is read and written once per cycle, a bypass register covering
// back-to-back hits. A result passes the queue, the lookup stage and the
// output register, and is held back while an earlier result waits on m_.
// Synchronous reset clears control and the 64 per-channel valid flags at
// once; no clearing pass, the block takes requests from the first cycle.
// A stalled m_ side freezes the back stage only; the 4-deep queue keeps
// s_tready high until it fills.
module threshold_spike_detector_top (
  input  logic        clk,
  input  logic        rst,
  // stream in
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // [5:0] channel, [21:6] sample, [36:22] threshold_value
  input  logic [0:0]  s_tuser,   // [0] operation
  // stream out
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [9:0] global_channel, [24:10] peak_amplitude
  // APB config
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  tsd_pkg::cfg_t   cfg;
  logic            cfg_wr;
  logic            queue_full;
  logic            queue_empty;
  logic            push;
  logic            pop;
  tsd_pkg::item_t  push_item;
  tsd_pkg::item_t  head;
  logic [tsd_pkg::GCH_W-1:0] out_channel;
  logic [tsd_pkg::AMP_W-1:0] out_peak;

  // ---- config registers; to be written only while idle (the block does not enforce this), so no shadowing ----
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.blind  <= tsd_pkg::BLIND_RESET;
      cfg.detect <= tsd_pkg::DET_RESET;
      cfg.group  <= tsd_pkg::GRP_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        tsd_pkg::REG_BLIND:  cfg.blind  <= pwdata[tsd_pkg::BLIND_W-1:0];
        tsd_pkg::REG_DETECT: cfg.detect <= pwdata[tsd_pkg::DET_W-1:0];
        tsd_pkg::REG_GROUP:  cfg.group  <= pwdata[tsd_pkg::GRP_W-1:0];
        default: ;  // unmapped: ignored
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      tsd_pkg::REG_BLIND:  prdata = 32'(cfg.blind);
      tsd_pkg::REG_DETECT: prdata = 32'(cfg.detect);
      tsd_pkg::REG_GROUP:  prdata = 32'(cfg.group);
      default:             prdata = '0;
    endcase
  end

  // ---- front: negate, clip and classify ----
  tsd_front u_front (
    .in_valid     (s_tvalid),
    .in_op        (s_tuser[0]),
    .in_channel   (s_tdata[5:0]),
    .in_sample    (s_tdata[21:6]),
    .in_threshold (s_tdata[36:22]),
    .queue_full   (queue_full),
    .in_ready     (s_tready),
    .push         (push),
    .push_item    (push_item)
  );

  // ---- decoupling queue ----
  tsd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (queue_full),
    .pop       (pop),
    .empty     (queue_empty),
    .head      (head)
  );

  // ---- back: per-channel phase tracking and spike report ----
  tsd_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .queue_empty (queue_empty),
    .head        (head),
    .pop         (pop),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .out_channel (out_channel),
    .out_peak    (out_peak)
  );

  assign m_tdata = {7'b0, out_peak, out_channel};

endmodule

[sim/testbench.sv]
`timescale 1ns / 1ps

// Stream-level check of the spike detector: directed script first, then random
// phases under several register settings, every result scored against a
// behavioural model of the per-channel counter, peak and threshold, or a scripted value.
module testbench;

  // Sender and receiver both pause at random; the long hold on the result side
  // fills the internal queue so the input stalls.
  localparam int LONG_HOLD   = 300;

  typedef struct packed {
    logic [tsd_pkg::GCH_W-1:0] gch;
    logic [tsd_pkg::AMP_W-1:0] peak;
  } spike_t;

  // How a script row is scored: by the model, as quiet, or by a value typed in here.
  typedef enum logic [1:0] {ROW_PREDICT, ROW_QUIET, ROW_SPIKE} row_kind_t;

  typedef struct packed {
    logic                      op;
    logic [tsd_pkg::CH_W-1:0]  ch;
    logic [15:0]               smp;
    logic [tsd_pkg::AMP_W-1:0] thr;
    int                        reps;
    row_kind_t                 kind;
    logic [tsd_pkg::GCH_W-1:0] gch;
    logic [tsd_pkg::AMP_W-1:0] peak;
  } script_row_t;

  typedef struct packed {
    int blind;
    int detect;
    int grp;
    int items;
    int base;   // first channel of the busy set
    int hot;    // size of the busy set
    bit idle;
    bit hold;
  } phase_t;

  // Script runs with blind 3, detect 2, group 15, so channel 0 reports as 960
  // and channel 63 as 1023. Channels leave reset blind for 40 samples.
  localparam script_row_t SCRIPT [24] = '{
    '{tsd_pkg::OP_LOAD,   6'd0,  16'h0000,    15'd100,  1,  ROW_QUIET, 10'd0,    15'd0},
    '{tsd_pkg::OP_LOAD,   6'd63, 16'h0000,    15'd0,    1,  ROW_QUIET, 10'd0,    15'd0},
    '{tsd_pkg::OP_SAMPLE, 6'd0,  16'h8000,    15'd0,    40, ROW_QUIET, 10'd0,    15'd0},
    '{tsd_pkg::OP_SAMPLE, 6'd0,  -16'sd100,   15'd0,    1,  ROW_QUIET, 10'd0,    15'd0},
    '{tsd_pkg::OP_SAMPLE, 6'd0,  16'h7FFF,    15'd0,    1,  ROW_QUIET, 10'd0,    15'd0},
    '{tsd_pkg::OP_SAMPLE, 6'd0,  -16'sd101,   15'd0,    1,  ROW_QUIET, 10'd0,    15'd0},
    '{tsd_pkg::OP_SAMPLE, 6'd0,  -16'sd50,    15'd0,    1,  ROW_QUIET, 10'd0,    15'd0},
    '{tsd_pkg::OP_SAMPLE, 6'd0,  -16'sd200,   15'd0,    1,  ROW_QUIET, 10'd0,    15'd0},
    '{tsd_pkg::OP_SAMPLE, 6'd0,  16'h0000,    15'd0,    1,  ROW_QUIET, 10'd0,    15'd0},
    '{tsd_pkg::OP_SAMPLE, 6'd0,  -16'sd200,   15'd0,    1,  ROW_SPIKE, 10'd960,  15'd200},
    '{tsd_pkg::OP_SAMPLE, 6'd0,  16'h8000,    15'd0,    1,  ROW_QUIET, 10'd0,    15'd0},
    '{tsd_pkg::OP_SAMPLE, 6'd0,  16'h8000,    15'd0,    1,  ROW_QUIET, 10'd0,    15'd0},
    '{tsd_pkg::OP_SAMPLE, 6'd0,  -16'sd32767, 15'd0,    1,  ROW_QUIET, 10'd0,    15'd0},
    '{tsd_pkg::OP_SAMPLE, 6'd0,  -16'sd1,     15'd0,    1,  ROW_SPIKE, 10'd960,  15'd32767},
    '{tsd_pkg::OP_SAMPLE, 6'd63, 16'h0000,    15'h7FFF, 40, ROW_QUIET, 10'd0,    15'd0},
    '{tsd_pkg::OP_SAMPLE, 6'd63, 16'h0000,    15'd0,    1,  ROW_QUIET, 10'd0,    15'd0},
    '{tsd_pkg::OP_SAMPLE, 6'd63, -16'sd1,     15'd0,    1,  ROW_QUIET, 10'd0,    15'd0},
    '{tsd_pkg::OP_LOAD,   6'd63, 16'hFFFF,    15'h7FFF, 1,  ROW_QUIET, 10'd0,    15'd0},
    '{tsd_pkg::OP_SAMPLE, 6'd63, 16'h0000,    15'd0,    1,  ROW_QUIET, 10'd0,    15'd0},
    '{tsd_pkg::OP_SAMPLE, 6'd63, 16'h0000,    15'd0,    1,  ROW_SPIKE, 10'd1023, 15'd1},
    '{tsd_pkg::OP_SAMPLE, 6'd63, -16'sd5,     15'd0,    1,  ROW_PREDICT, 10'd0,  15'd0},
    '{tsd_pkg::OP_SAMPLE, 6'd63, 16'h8000,    15'd0,    1,  ROW_PREDICT, 10'd0,  15'd0},
    '{tsd_pkg::OP_SAMPLE, 6'd1,  16'h8000,    15'h7FFF, 1,  ROW_PREDICT, 10'd0,  15'd0},
    '{tsd_pkg::OP_LOAD,   6'd1,  16'h5555,    15'h7FFF, 1,  ROW_PREDICT, 10'd0,  15'd0}
  };

  // Random phases. Extremes phase keeps to the top channels: a 2047-sample
  // onset window would otherwise lock the busy channels for the rest of the run.
  localparam phase_t PHASES [6] = '{
    '{40,   10,   0,  250, 0,  2,  1'b1, 1'b1},  // reset values, long result hold
    '{1,    1,    3,  300, 0,  8,  1'b1, 1'b0},
    '{5,    12,   7,  250, 0,  4,  1'b1, 1'b0},  // blind shorter than the window
    '{8,    0,    1,  150, 0,  4,  1'b1, 1'b0},  // zero window, never confirms
    '{4095, 2047, 15, 80,  48, 16, 1'b1, 1'b0},  // register extremes
    '{2,    3,    9,  400, 0,  8,  1'b0, 1'b0}   // closing stretch, no idling
  };

  logic        clk = 1'b0;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [39:0] s_tdata;    // [5:0] channel, [21:6] sample, [36:22] threshold_value
  logic [0:0]  s_tuser;    // [0] operation
  logic        m_tvalid;
  logic        m_tready;
  logic [31:0] m_tdata;    // [9:0] global_channel, [24:10] peak_amplitude
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  // Model state: one entry per channel plus a mirror of the registers.
  int counter_of   [tsd_pkg::CHANNELS];
  int peak_of      [tsd_pkg::CHANNELS];
  int threshold_of [tsd_pkg::CHANNELS];
  int cfg_blind;
  int cfg_detect;
  int cfg_grp;

  spike_t spikes_due [$];
  int     mismatches = 0;
  bit     idling = 1'b1;
  bit     sink_hold = 1'b0;

  threshold_spike_detector_top DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    #10_000_000;
    $display("testbench failed");
    $finish;
  end

  task automatic flag_mismatch(string what, int got, int want);
    $display("MISMATCH %s: got %0d, expected %0d", what, got, want);
    mismatches++;
  endtask

  // One request through the channel model. Returns 1 when it confirms a spike.
  function automatic bit advance_channel(logic op, logic [tsd_pkg::CH_W-1:0] ch,
                                         logic signed [15:0] smp,
                                         logic [tsd_pkg::AMP_W-1:0] thr,
                                         output spike_t hit);
    int neg;
    int cnt;
    hit = '0;
    if (op == tsd_pkg::OP_LOAD) begin
      threshold_of[ch] = thr;  // counter and peak untouched
      return 1'b0;
    end
    // negation saturates: the most negative sample maps to full scale
    neg = (smp == 16'sh8000) ? 32767 : -int'(smp);
    cnt = counter_of[ch];
    if (cnt > 0) begin
      counter_of[ch] = cnt - 1;                   // blind
    end else if (cnt == 0) begin
      if (neg > threshold_of[ch]) begin           // armed: onset starts
        counter_of[ch] = -cfg_detect;
        peak_of[ch]    = neg;
      end
    end else if (neg > peak_of[ch]) begin         // onset: bigger peak restarts window
      counter_of[ch] = -cfg_detect;
      peak_of[ch]    = neg;
    end else if (cnt + 1 != 0) begin
      counter_of[ch] = cnt + 1;
    end else begin                                // window expired: report and blind
      counter_of[ch] = (cfg_blind > cfg_detect) ? cfg_blind - cfg_detect : 0;
      hit.gch  = tsd_pkg::GCH_W'(cfg_grp * tsd_pkg::CHANNELS + int'(ch));
      hit.peak = tsd_pkg::AMP_W'(peak_of[ch]);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Present one request, hold it until taken, then run the model on it.
  // Called and returns at a falling edge.
  task automatic offer(logic op, logic [tsd_pkg::CH_W-1:0] ch, logic [15:0] smp,
                       logic [tsd_pkg::AMP_W-1:0] thr, output bit hit, output spike_t due);
    s_tuser  <= op;
    s_tdata  <= {3'b000, thr, smp, ch};
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    hit = advance_channel(op, ch, smp, thr, due);
    @(negedge clk);
  endtask

  task automatic sender_gap();
    if (idling && $urandom_range(0, 9) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk);
    end
  endtask

  // Stop sending and wait for every pending spike, then let requests that cause
  // none clear the three-stage pipe.
  task automatic settle();
    s_tvalid <= 1'b0;
    while (spikes_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    @(negedge clk);
  endtask

  // APB write then read-back; register mirror follows the write.
  task automatic write_reg(logic [1:0] idx, int val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= 32'(val);
    @(negedge clk) penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(negedge clk) penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== 32'(val)) flag_mismatch("register read-back", int'(prdata), val);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
    case (idx)
      tsd_pkg::REG_BLIND:  cfg_blind  = val;
      tsd_pkg::REG_DETECT: cfg_detect = val;
      tsd_pkg::REG_GROUP:  cfg_grp    = val;
      default: ;
    endcase
  endtask

  // Mostly negative samples near typical thresholds on a small busy set of
  // channels, so onsets and confirmations happen often; the rest is noise.
  task automatic random_request(int base, int hot);
    logic                      op;
    logic [tsd_pkg::CH_W-1:0]  ch;
    logic [15:0]               smp;
    logic [tsd_pkg::AMP_W-1:0] thr;
    int                        pick;
    bit                        hit;
    spike_t                    due;
    op = ($urandom_range(0, 99) < 8) ? tsd_pkg::OP_LOAD : tsd_pkg::OP_SAMPLE;
    if (base == 0 && $urandom_range(0, 99) < 15) begin
      ch = tsd_pkg::CH_W'($urandom_range(0, 63));
    end else begin
      ch = tsd_pkg::CH_W'(base + $urandom_range(0, hot - 1));
    end
    pick = $urandom_range(0, 99);
    if (pick < 65) smp = 16'(0 - $urandom_range(0, 24000));
    else if (pick < 80) smp = 16'($urandom_range(0, 32767));
    else if (pick < 88) begin
      case ($urandom_range(0, 3))
        0: smp = 16'h8000;
        1: smp = 16'h7FFF;
        2: smp = 16'h0000;
        default: smp = 16'hFFFF;
      endcase
    end else smp = 16'($urandom);
    pick = $urandom_range(0, 9);
    if (pick == 0) thr = '0;
    else if (pick == 1) thr = tsd_pkg::AMP_MAX;
    else if (pick < 4) thr = tsd_pkg::AMP_W'($urandom);
    else thr = tsd_pkg::AMP_W'($urandom_range(1000, 20000));
    offer(op, ch, smp, thr, hit, due);
    if (hit) spikes_due.insert(spikes_due.size(), due);
    sender_gap();
  endtask

  // Result side: random stalls, occasional long hold counted here, and
  // long stretches of steady acceptance.
  initial begin
    m_tready = 1'b0;
    wait (!rst);
    @(negedge clk);
    forever begin
      if (sink_hold) begin
        m_tready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        sink_hold = 1'b0;
      end else if (idling && $urandom_range(0, 7) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(negedge clk);
      end else begin
        m_tready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(negedge clk);
      end
    end
  end

  // Score each delivered spike against the oldest pending one.
  always @(posedge clk) begin : score
    spike_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (spikes_due.size() == 0) begin
        flag_mismatch("spike with nothing pending, channel", int'(m_tdata[9:0]), -1);
      end else begin
        want = spikes_due.pop_front();
        if (m_tdata[9:0] !== want.gch)
          flag_mismatch("global channel", int'(m_tdata[9:0]), int'(want.gch));
        if (m_tdata[24:10] !== want.peak)
          flag_mismatch("peak amplitude", int'(m_tdata[24:10]), int'(want.peak));
      end
    end
  end

  initial begin
    int     n;
    int     i;
    int     k;
    bit     hit;
    spike_t due;
    phase_t ph;

    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tuser  = '0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    cfg_blind  = int'(tsd_pkg::BLIND_RESET);
    cfg_detect = int'(tsd_pkg::DET_RESET);
    cfg_grp    = int'(tsd_pkg::GRP_RESET);
    for (i = 0; i < tsd_pkg::CHANNELS; i++) begin
      counter_of[i]   = int'(tsd_pkg::BLIND_RESET);
      peak_of[i]      = 0;
      threshold_of[i] = int'(tsd_pkg::AMP_MAX);
    end

    repeat (12) @(posedge clk);
    @(negedge clk) rst <= 1'b0;
    @(negedge clk);

    // Directed script
    write_reg(tsd_pkg::REG_BLIND, 3);
    write_reg(tsd_pkg::REG_DETECT, 2);
    write_reg(tsd_pkg::REG_GROUP, 15);
    foreach (SCRIPT[r]) begin
      for (n = 0; n < SCRIPT[r].reps; n++) begin
        offer(SCRIPT[r].op, SCRIPT[r].ch, SCRIPT[r].smp, SCRIPT[r].thr, hit, due);
        case (SCRIPT[r].kind)
          ROW_PREDICT: if (hit) spikes_due.insert(spikes_due.size(), due);
          ROW_SPIKE:   spikes_due.insert(spikes_due.size(),
                                         spike_t'{SCRIPT[r].gch, SCRIPT[r].peak});
          default: ;
        endcase
        sender_gap();
      end
    end

    // Random phases; each starts from an idle block with new registers
    foreach (PHASES[p]) begin
      ph = PHASES[p];
      settle();
      idling = ph.idle;
      write_reg(tsd_pkg::REG_BLIND, ph.blind);
      write_reg(tsd_pkg::REG_DETECT, ph.detect);
      write_reg(tsd_pkg::REG_GROUP, ph.grp);
      for (i = 0; i < ph.items; i++) begin
        if (ph.hold && i == ph.items / 3) sink_hold = 1'b1;
        random_request(ph.base, ph.hot);
      end
    end

    // Drain, bounded, then allow the pipe to empty
    s_tvalid <= 1'b0;
    for (k = 0; k < 20000 && spikes_due.size() != 0; k++) @(posedge clk);
    repeat (8) @(posedge clk);
    if (spikes_due.size() != 0) flag_mismatch("spikes never delivered", 0, spikes_due.size());
    if (mismatches == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

[files.f]
sv/tsd_pkg.sv
sv/tsd_ram.sv
sv/tsd_front.sv
sv/tsd_queue.sv
sv/tsd_back.sv
sv/threshold_spike_detector_top.sv
sim/testbench.sv
